// ===== hw/rtl/tea_pkg.sv =====
// ----------------------------------------------------------------------------
// TEA cipher package
// Shared widths, register indexes, operation codes and the round mix function.
// ----------------------------------------------------------------------------
package tea_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned CfgIdxW = 3;

  typedef logic [WordW-1:0]   word_t;
  typedef logic [CfgIdxW-1:0] cfg_idx_t;

  // Configuration register indexes.
  localparam cfg_idx_t KeyWord0Idx = 3'd0;
  localparam cfg_idx_t KeyWord1Idx = 3'd1;
  localparam cfg_idx_t KeyWord2Idx = 3'd2;
  localparam cfg_idx_t KeyWord3Idx = 3'd3;

  // Operation codes carried by the kind field.
  localparam logic KindEncrypt = 1'b0;
  localparam logic KindDecrypt = 1'b1;

  // Round constant of the cipher.
  localparam word_t TeaDelta = 32'h9e37_79b9;

  // One Feistel mix: ((x << 4) + ka) ^ (x + sum) ^ ((x >> 5) + kb).
  function automatic word_t tea_mix(word_t x, word_t sum, word_t ka, word_t kb);
    tea_mix = ((x << 4) + ka) ^ (x + sum) ^ ((x >> 5) + kb);
  endfunction

endpackage

// ===== hw/rtl/tea_block_cipher.sv =====
// ----------------------------------------------------------------------------
// TEA block cipher
// Fully pipelined TEA encrypt/decrypt engine, one 64-bit block per cycle.
// ----------------------------------------------------------------------------
// A block is accepted whenever start_i is high; busy_o stays low, so an item
// can be offered in every cycle and encrypt and decrypt items may be mixed
// freely. Each item comes out on first_result_o and second_result_o for a
// single cycle marked by valid_o. The receiver cannot stall the result: it
// must capture the item in the cycle valid_o is high. Each item passes
// through the round pipeline, which has one input register followed by one
// register stage per half round. The 128-bit key lives in four 32-bit
// registers written through the cfg_* port, which is always ready; writes
// to indexes above three are dropped. The key feeds every stage directly,
// so it may only be changed while no item is in flight.
module tea_block_cipher #(
  parameter int unsigned ROUNDS = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Item input.
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic                        kind_i,
  input  logic [31:0]                 first_word_i,
  input  logic [31:0]                 second_word_i,
  // Item output.
  output logic                        valid_o,
  output logic [31:0]                 first_result_o,
  output logic [31:0]                 second_result_o,
  // Configuration write channel.
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [tea_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]                 cfg_data_i
);

  // Each round is split into two half rounds; each half round gets its own
  // register stage so the path between registers is one mix plus one add.
  localparam int unsigned NStages = 2 * ROUNDS;

  tea_pkg::word_t key0_q, key1_q, key2_q, key3_q;

  // Pipeline registers: index 0 is the input register, index NStages feeds
  // the outputs.
  logic           valid_q [NStages+1];
  logic           kind_q  [NStages+1];
  tea_pkg::word_t v0_q    [NStages+1];
  tea_pkg::word_t v1_q    [NStages+1];

  logic accept;

  // The pipeline never stalls, so an item is always taken.
  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start_i & ~busy_o;

  // Key registers. Writes to unused indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key0_q <= '0;
      key1_q <= '0;
      key2_q <= '0;
      key3_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        tea_pkg::KeyWord0Idx: key0_q <= cfg_data_i;
        tea_pkg::KeyWord1Idx: key1_q <= cfg_data_i;
        tea_pkg::KeyWord2Idx: key2_q <= cfg_data_i;
        tea_pkg::KeyWord3Idx: key3_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q[0] <= 1'b0;
    end else begin
      valid_q[0] <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q[0] <= kind_i;
      v0_q[0]   <= first_word_i;
      v1_q[0]   <= second_word_i;
    end
  end

  // Half-round stages.
  for (genvar s = 0; s < NStages; s++) begin : g_stage
    // Encryption runs rounds forward with the sum counting up from delta;
    // decryption runs them backward with the sum counting down from
    // ROUNDS*delta (0xC6EF3720 for 32 rounds).
    localparam int unsigned Rnd = s / 2;
    localparam bit          Odd = (s % 2) == 1;
    localparam tea_pkg::word_t EncSum = 32'(tea_pkg::TeaDelta * 32'(Rnd + 1));
    localparam tea_pkg::word_t DecSum = 32'(tea_pkg::TeaDelta * 32'(ROUNDS - Rnd));

    logic           sel;
    tea_pkg::word_t src, dst, ka, kb, sum, mix, dst_new;
    tea_pkg::word_t v0_d, v1_d;

    // When sel is low the stage updates v0 from v1 with key words 0 and 1;
    // when high it updates v1 from v0 with key words 2 and 3. Decryption
    // takes the two halves of each round in the opposite order.
    always_comb begin
      sel     = kind_q[s] ^ Odd;
      src     = sel ? v0_q[s] : v1_q[s];
      dst     = sel ? v1_q[s] : v0_q[s];
      ka      = sel ? key2_q : key0_q;
      kb      = sel ? key3_q : key1_q;
      sum     = (kind_q[s] == tea_pkg::KindDecrypt) ? DecSum : EncSum;
      mix     = tea_pkg::tea_mix(src, sum, ka, kb);
      dst_new = (kind_q[s] == tea_pkg::KindDecrypt) ? dst - mix : dst + mix;
      v0_d    = sel ? v0_q[s] : dst_new;
      v1_d    = sel ? dst_new : v1_q[s];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s+1] <= 1'b0;
      end else begin
        valid_q[s+1] <= valid_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (valid_q[s]) begin
        kind_q[s+1] <= kind_q[s];
        v0_q[s+1]   <= v0_d;
        v1_q[s+1]   <= v1_d;
      end
    end
  end

  assign valid_o         = valid_q[NStages];
  assign first_result_o  = v0_q[NStages];
  assign second_result_o = v1_q[NStages];

endmodule

// ===== hw/rtl/tea_chk.sv =====
// ----------------------------------------------------------------------------
// TEA cipher port checker
// Watches the top-level ports for latency, ordering and handshake slips.
// ----------------------------------------------------------------------------
module tea_chk #(
  parameter int unsigned ROUNDS = 32
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        start_i,
  input logic                        busy_o,
  input logic                        kind_i,
  input logic [31:0]                 first_word_i,
  input logic [31:0]                 second_word_i,
  input logic                        valid_o,
  input logic [31:0]                 first_result_o,
  input logic [31:0]                 second_result_o,
  input logic                        cfg_valid_i,
  input logic                        cfg_ready_o
);

  localparam int unsigned Lat = 2 * ROUNDS + 1;

  logic           accept, cfg_wr, same;
  logic [Lat-1:0] acc_q, same_q;
  logic           prev_acc_q, prev_kind_q;
  logic [31:0]    prev_w0_q, prev_w1_q;

  assign accept = start_i & ~busy_o;
  assign cfg_wr = cfg_valid_i & cfg_ready_o;
  // This item repeats the one accepted in the cycle before.
  assign same   = accept && prev_acc_q && (kind_i == prev_kind_q) &&
                  (first_word_i == prev_w0_q) && (second_word_i == prev_w1_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q      <= '0;
      same_q     <= '0;
      prev_acc_q <= 1'b0;
    end else begin
      acc_q      <= {acc_q[Lat-2:0], accept};
      // A key write would make two neighboring items legitimately differ.
      same_q     <= cfg_wr ? '0 : {same_q[Lat-2:0], same};
      prev_acc_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    prev_kind_q <= kind_i;
    prev_w0_q   <= first_word_i;
    prev_w1_q   <= second_word_i;
  end

  a_fixed_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o == acc_q[Lat-1])
    else $error("result strobe does not follow an accepted item at fixed latency");

  a_repeat_same_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && same_q[Lat-1]) |->
      (first_result_o == $past(first_result_o)) &&
      (second_result_o == $past(second_result_o)))
    else $error("identical back-to-back items gave different results");

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_o)
    else $error("item refused although the pipeline never stalls");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write held off");

endmodule

bind tea_block_cipher tea_chk #(.ROUNDS(ROUNDS)) u_tea_chk (.*);

// ===== tb/sv/tb_tea_block_cipher.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TEA block cipher testbench
// Drives encrypt and decrypt items into the cipher under several keys and
// idle patterns, and checks every result item against an in-bench TEA model.
// ----------------------------------------------------------------------------
module tb_tea_block_cipher;

  // The bench assumes the block's default round count.
  localparam int unsigned    Rounds     = 32;
  localparam tea_pkg::word_t RoundDelta = 32'h9e37_79b9;
  // The wait spans the whole round pipeline; a little margin is added.
  localparam int unsigned DrainCycles = 2 * Rounds + 16;
  localparam int unsigned NumPhases     = 6;
  localparam int unsigned ItemsPerPhase = 314;
  localparam int unsigned MaxReports    = 10;

  typedef struct packed {
    tea_pkg::word_t first;
    tea_pkg::word_t second;
  } block_t;

  // Holds the current key, computes the cipher of each accepted item and
  // compares results in order against the blocks still awaited.
  class tea_block_checker;
    tea_pkg::word_t key_words[4];
    block_t         awaited_blocks[$];
    block_t         last_cipher;
    int unsigned    n_errors;

    function new();
      foreach (key_words[i]) key_words[i] = '0;
      last_cipher = '0;
      n_errors    = 0;
    endfunction

    function void flag(string msg);
      n_errors++;
      if (n_errors <= MaxReports) $display("MISMATCH: %s", msg);
    endfunction

    // Writes beyond the last key word are dropped, just as in the block.
    function void set_key(tea_pkg::cfg_idx_t idx, tea_pkg::word_t data);
      if (idx <= tea_pkg::KeyWord3Idx) key_words[idx] = data;
    endfunction

    function tea_pkg::word_t half_round_mix(tea_pkg::word_t v, tea_pkg::word_t s,
                                            tea_pkg::word_t ka, tea_pkg::word_t kb);
      half_round_mix = ((v << 4) + ka) ^ (v + s) ^ ((v >> 5) + kb);
    endfunction

    function block_t cipher_block(logic kind, tea_pkg::word_t a, tea_pkg::word_t b);
      tea_pkg::word_t y, z, sum;
      y = a;
      z = b;
      if (kind == tea_pkg::KindDecrypt) begin
        sum = RoundDelta * tea_pkg::word_t'(Rounds);
        repeat (Rounds) begin
          z   = z - half_round_mix(y, sum, key_words[2], key_words[3]);
          y   = y - half_round_mix(z, sum, key_words[0], key_words[1]);
          sum = sum - RoundDelta;
        end
      end else begin
        sum = '0;
        repeat (Rounds) begin
          sum = sum + RoundDelta;
          y   = y + half_round_mix(z, sum, key_words[0], key_words[1]);
          z   = z + half_round_mix(y, sum, key_words[2], key_words[3]);
        end
      end
      cipher_block = '{first: y, second: z};
    endfunction

    function void note_block(logic kind, tea_pkg::word_t a, tea_pkg::word_t b);
      block_t out;
      out = cipher_block(kind, a, b);
      if (kind == tea_pkg::KindEncrypt) last_cipher = out;
      awaited_blocks.push_back(out);
    endfunction

    function void check_result(tea_pkg::word_t r0, tea_pkg::word_t r1);
      block_t want;
      if (awaited_blocks.size() == 0) begin
        flag($sformatf("result %h %h arrived with nothing awaited", r0, r1));
        return;
      end
      want = awaited_blocks.pop_front();
      if (r0 !== want.first)
        flag($sformatf("first_result expected %h got %h", want.first, r0));
      if (r1 !== want.second)
        flag($sformatf("second_result expected %h got %h", want.second, r1));
    endfunction

    function int unsigned pending();
      pending = awaited_blocks.size();
    endfunction

    function void check_leftovers();
      if (awaited_blocks.size() != 0)
        flag($sformatf("%0d result items never arrived", awaited_blocks.size()));
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              start_i;
  logic              busy_o;
  logic              kind_i;
  tea_pkg::word_t    first_word_i;
  tea_pkg::word_t    second_word_i;
  logic              valid_o;
  tea_pkg::word_t    first_result_o;
  tea_pkg::word_t    second_result_o;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  tea_pkg::cfg_idx_t cfg_index_i;
  tea_pkg::word_t    cfg_data_i;

  tea_block_checker book = new();

  tea_block_cipher u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .kind_i          (kind_i),
    .first_word_i    (first_word_i),
    .second_word_i   (second_word_i),
    .valid_o         (valid_o),
    .first_result_o  (first_result_o),
    .second_result_o (second_result_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // All handshakes are observed here, at the rising edge, so the model sees
  // key writes, accepted items and result items in true cycle order.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) book.set_key(cfg_index_i, cfg_data_i);
      if (start_i && !busy_o) book.note_block(kind_i, first_word_i, second_word_i);
      if (valid_o) book.check_result(first_result_o, second_result_o);
    end
  end

  // Offers one item from the next falling edge and holds it until taken.
  // Start is left high so that a following item goes out in the next cycle.
  task automatic send_block(logic kind, tea_pkg::word_t a, tea_pkg::word_t b);
    @(negedge clk_i);
    start_i       <= 1'b1;
    kind_i        <= kind;
    first_word_i  <= a;
    second_word_i <= b;
    do @(posedge clk_i); while (busy_o);
  endtask

  // An idle step with nothing offered; the payload carries noise that the block
  // has to ignore.
  task automatic idle_cycle();
    @(negedge clk_i);
    start_i       <= 1'b0;
    kind_i        <= 1'($urandom);
    first_word_i  <= $urandom;
    second_word_i <= $urandom;
  endtask

  task automatic write_key(tea_pkg::cfg_idx_t idx, tea_pkg::word_t data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Lowers start and waits until every awaited result item has come back.
  // Each item yields one result, so an empty list means an empty pipeline.
  task automatic drain();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (book.pending() != 0) @(posedge clk_i);
  endtask

  // Edge values and bit patterns turn up often; one-hot words probe the
  // shift and carry paths of the mix.
  function automatic tea_pkg::word_t pick_word();
    case ($urandom_range(7))
      0:       pick_word = '0;
      1:       pick_word = '1;
      2:       pick_word = tea_pkg::word_t'(1) << $urandom_range(31);
      default: pick_word = $urandom;
    endcase
  endfunction

  // Loads a fresh key for a phase. Early phases use the extremes, the rest
  // random words. Writes to the unused indexes go out as well, and the model
  // and the block must both drop them.
  task automatic load_key(int unsigned phase);
    tea_pkg::word_t words[4];
    foreach (words[i]) begin
      case (phase)
        0:       words[i] = '1;
        1:       words[i] = '0;
        2:       words[i] = (i % 2 == 0) ? 32'haaaa_aaaa : 32'h5555_5555;
        3:       words[i] = (i % 2 == 0) ? '1 : '0;
        default: words[i] = $urandom;
      endcase
    end
    write_key(tea_pkg::KeyWord3Idx, words[3]);
    write_key(tea_pkg::cfg_idx_t'(tea_pkg::KeyWord3Idx + 1), $urandom);
    write_key(tea_pkg::KeyWord1Idx, words[1]);
    write_key(tea_pkg::KeyWord0Idx, words[0]);
    write_key(tea_pkg::cfg_idx_t'($urandom_range(tea_pkg::KeyWord3Idx + 1,
                                                 (1 << tea_pkg::CfgIdxW) - 1)),
              $urandom);
    write_key(tea_pkg::KeyWord2Idx, words[2]);
  endtask

  // Edge blocks through both operations, under whatever key is loaded.
  task automatic run_directed();
    tea_pkg::word_t pairs[7][2];
    pairs = '{'{32'h0, 32'h0}, '{'1, '1}, '{32'h0, '1}, '{'1, 32'h0},
              '{32'haaaa_aaaa, 32'h5555_5555}, '{32'h8000_0000, 32'h1},
              '{32'h1, 32'h8000_0000}};
    foreach (pairs[i]) send_block(tea_pkg::KindEncrypt, pairs[i][0], pairs[i][1]);
    foreach (pairs[i]) send_block(tea_pkg::KindDecrypt, pairs[i][0], pairs[i][1]);
    // Decrypting the last ciphertext must give its plaintext back.
    send_block(tea_pkg::KindDecrypt, book.last_cipher.first, book.last_cipher.second);
    send_block(tea_pkg::KindEncrypt, $urandom, $urandom);
  endtask

  // Random items; before each one the sender keeps idling while a draw falls below idle_pct percent.
  // Now and then a burst of back-to-back items breaks the idle pattern.
  task automatic run_random(int unsigned count, int unsigned idle_pct);
    int unsigned burst;
    logic        kind;
    burst = 0;
    for (int unsigned n = 0; n < count; n++) begin
      if (burst != 0) burst--;
      else if ($urandom_range(31) == 0) burst = $urandom_range(8, 40);
      if (burst == 0) begin
        while ($urandom_range(99) < idle_pct) idle_cycle();
      end
      if ($urandom_range(7) == 0) begin
        // Round trip on a recent ciphertext: the plaintext must reappear.
        send_block(tea_pkg::KindDecrypt, book.last_cipher.first,
                   book.last_cipher.second);
      end else begin
        kind = 1'($urandom);
        send_block(kind, pick_word(), pick_word());
      end
    end
  endtask

  initial begin : stimulus
    int unsigned idle_pcts[NumPhases];
    // The receiver cannot stall; phases 0 and 2 run without idling.
    idle_pcts = '{0, 84, 0, 32, 84, 32};
    rst_ni        = 1'b0;
    start_i       = 1'b0;
    kind_i        = 1'b0;
    first_word_i  = '0;
    second_word_i = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // First pass runs under the all-zero key left by reset.
    run_directed();
    for (int unsigned p = 0; p < NumPhases; p++) begin
      drain();
      load_key(p);
      run_random(ItemsPerPhase, idle_pcts[p]);
    end
    drain();

    // Extra cycles catch any stray result item after the last one expected.
    repeat (DrainCycles) @(posedge clk_i);
    book.check_leftovers();
    if (book.n_errors == 0) begin
      $display("tb_tea_block_cipher: clean");
    end else begin
      $display("tb_tea_block_cipher: errors");
    end
    $finish;
  end

  // This bound lies far above the time that the whole run needs.
  initial begin : watchdog
    #5ms;
    $display("tb_tea_block_cipher: errors");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/tea_pkg.sv
hw/rtl/tea_block_cipher.sv
hw/rtl/tea_chk.sv
tb/sv/tb_tea_block_cipher.sv
